/* rtl/tcw_pkg.sv */
// Shared types, codes and constants for the text console writer.
`default_nettype none

package tcw_pkg;

  // Default screen geometry
  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  // Field widths fixed by the interface
  localparam int CMD_W   = 2;
  localparam int CHAR_W  = 8;
  localparam int INDEX_W = 11;
  localparam int ROW_W   = 5;
  localparam int COL_W   = 7;
  localparam int CELL_W  = 16;
  localparam int COLOR_W = 8;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NOP   = 2'd3;

  // Character and attribute constants
  localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'd10;
  localparam logic [CHAR_W-1:0]  BLANK_CODE   = 8'h20;
  localparam logic [COLOR_W-1:0] RESET_COLOR  = 8'h0F;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_FILL
  } state_t;

  // One result item
  typedef struct packed {
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
    logic [CELL_W-1:0] cell_data;
    logic              scrolled;
  } res_t;

endpackage

`default_nettype wire

/* rtl/text_console_writer.sv */
// Text console writer top level: controller, screen memory and result register.
//
// Channels: in_* (cmd, char_code, cell_index) and out_* (cursor_row, cursor_col,
// cell_data, scrolled) use valid/ready; cfg_* writes the text color at any time
// (cfg_ready is always high) and is meant to change only while the block is idle.
// Every input item gives exactly one result item.
// Work per item, done by the screen memory sequencer:
//   put without scroll, clear-free no-op, out-of-range read: result loaded on acceptance
//   read: the registered memory read, then the result is loaded
//   put that scrolls: one bottom row blanked, one cell a cycle (rows rotate
//   through a base pointer, nothing is copied)
//   clear: every cell written once
// Results sit in an output register; a new item is taken while the block is idle
// and that register is empty or being emptied in the same cycle. A stalled
// receiver holds in_ready low. Reset (rst_n low, synchronous) homes the cursor,
// sets the color to 0x0F and clears all ROWS*COLUMNS cells before accepting an item.
`default_nettype none

module text_console_writer #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [tcw_pkg::CMD_W-1:0]     in_cmd,
  input  wire logic [tcw_pkg::CHAR_W-1:0]    in_char_code,
  input  wire logic [tcw_pkg::INDEX_W-1:0]   in_cell_index,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [tcw_pkg::ROW_W-1:0]     out_cursor_row,
  output logic      [tcw_pkg::COL_W-1:0]     out_cursor_col,
  output logic      [tcw_pkg::CELL_W-1:0]    out_cell_data,
  output logic                               out_scrolled,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [tcw_pkg::COLOR_W-1:0]   cfg_text_color
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);

  logic                        out_valid_r, out_valid_nxt;
  tcw_pkg::res_t               out_r;
  tcw_pkg::res_t               res;
  logic                        res_load;
  logic                        out_free;
  logic                        mem_we, mem_re;
  logic [AW-1:0]               mem_waddr, mem_raddr;
  logic [tcw_pkg::CELL_W-1:0]  mem_wdata, mem_rdata;

  assign out_free = !out_valid_r || out_ready;

  tcw_ctrl #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_char_code   (in_char_code),
    .in_cell_index  (in_cell_index),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_text_color (cfg_text_color),
    .out_free       (out_free),
    .res_load       (res_load),
    .res            (res),
    .mem_we         (mem_we),
    .mem_waddr      (mem_waddr),
    .mem_wdata      (mem_wdata),
    .mem_re         (mem_re),
    .mem_raddr      (mem_raddr),
    .mem_rdata      (mem_rdata)
  );

  tcw_screen_ram #(
    .DEPTH (CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cursor_row = out_r.cursor_row;
  assign out_cursor_col = out_r.cursor_col;
  assign out_cell_data  = out_r.cell_data;
  assign out_scrolled   = out_r.scrolled;

  // A result is only loaded into a free slot
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> out_free)
    else $error("result loaded over an untaken item");

endmodule

`default_nettype wire

/* rtl/tcw_screen_ram.sv */
// Screen cell memory: one write port, one registered read port.
`default_nettype none

module tcw_screen_ram #(
  parameter int DEPTH = tcw_pkg::COLUMNS_DEF * tcw_pkg::ROWS_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [AW-1:0]             waddr,
  input  wire logic [tcw_pkg::CELL_W-1:0] wdata,
  input  wire logic                      re,
  input  wire logic [AW-1:0]             raddr,
  output logic      [tcw_pkg::CELL_W-1:0] rdata
);

  logic [tcw_pkg::CELL_W-1:0] mem_q [DEPTH];
  logic [tcw_pkg::CELL_W-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
  end

  // Read port, registered
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_q[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* rtl/tcw_ctrl.sv */
// Console controller: cursor, row rotation, fill sequencer and memory access.
`default_nettype none

module tcw_ctrl #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF,
  localparam int AW = $clog2(ROWS * COLUMNS)
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input channel
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [tcw_pkg::CMD_W-1:0]     in_cmd,
  input  wire logic [tcw_pkg::CHAR_W-1:0]    in_char_code,
  input  wire logic [tcw_pkg::INDEX_W-1:0]   in_cell_index,
  // configuration
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [tcw_pkg::COLOR_W-1:0]   cfg_text_color,
  // result hand-off
  input  wire logic                          out_free,
  output logic                               res_load,
  output tcw_pkg::res_t                      res,
  // screen memory
  output logic                               mem_we,
  output logic      [AW-1:0]                 mem_waddr,
  output logic      [tcw_pkg::CELL_W-1:0]    mem_wdata,
  output logic                               mem_re,
  output logic      [AW-1:0]                 mem_raddr,
  input  wire logic [tcw_pkg::CELL_W-1:0]    mem_rdata
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int RW    = $clog2(ROWS);
  localparam int CLW   = $clog2(COLUMNS);
  localparam int CW    = $clog2(CELLS + 1);
  localparam int SW    = ((AW > tcw_pkg::INDEX_W) ? AW : tcw_pkg::INDEX_W) + 1;
  localparam int RWX   = (RW > tcw_pkg::ROW_W) ? RW : tcw_pkg::ROW_W;
  localparam int CLX   = (CLW > tcw_pkg::COL_W) ? CLW : tcw_pkg::COL_W;

  tcw_pkg::state_t state_r, state_nxt;

  logic [RW-1:0]                  row_r, row_nxt;
  logic [CLW-1:0]                 col_r, col_nxt;
  logic [AW-1:0]                  top_r, top_nxt;     // physical base of logical row 0
  logic [AW-1:0]                  fill_addr_r, fill_addr_nxt;
  logic [CW-1:0]                  fill_cnt_r, fill_cnt_nxt;
  logic [tcw_pkg::CELL_W-1:0]     fill_val_r, fill_val_nxt;
  logic                           fill_rep_r, fill_rep_nxt;
  logic                           scr_r, scr_nxt;
  logic [tcw_pkg::COLOR_W-1:0]    color_r;

  logic          in_fire;
  logic          is_put, is_clr, is_read, is_nl;
  logic          last_col, last_row, adv_row, do_scroll, in_range, fill_last;
  logic [SW-1:0] cursor_lin, lin_sel, phys_sum, phys_wrap;
  logic [AW-1:0] phys_addr;
  logic [RWX-1:0] row_x;
  logic [CLX-1:0] col_x;

  // Config register, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_r <= tcw_pkg::RESET_COLOR;
    end else if (cfg_valid) begin
      color_r <= cfg_text_color;
    end
  end

  // Command decode
  assign in_ready  = (state_r == tcw_pkg::ST_IDLE) && out_free;
  assign in_fire   = in_valid && in_ready;
  assign is_put    = (in_cmd == tcw_pkg::CMD_PUT);
  assign is_clr    = (in_cmd == tcw_pkg::CMD_CLEAR);
  assign is_read   = (in_cmd == tcw_pkg::CMD_READ);
  assign is_nl     = (in_char_code == tcw_pkg::NEWLINE_CODE);
  assign last_col  = (col_r == CLW'(COLUMNS - 1));
  assign last_row  = (row_r == RW'(ROWS - 1));
  assign adv_row   = is_put && (is_nl || last_col);
  assign do_scroll = adv_row && last_row;
  assign in_range  = (SW'(in_cell_index) < SW'(CELLS));
  assign fill_last = (fill_cnt_r == CW'(1));

  // Logical to physical address: rows rotate around top_r
  assign cursor_lin = SW'(row_r) * SW'(COLUMNS) + SW'(col_r);
  assign lin_sel    = is_read ? SW'(in_cell_index) : cursor_lin;
  assign phys_sum   = lin_sel + SW'(top_r);
  assign phys_wrap  = (phys_sum >= SW'(CELLS)) ? (phys_sum - SW'(CELLS)) : phys_sum;
  assign phys_addr  = phys_wrap[AW-1:0];

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tcw_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (is_clr || do_scroll) begin
            state_nxt = tcw_pkg::ST_FILL;
          end else if (is_read && in_range) begin
            state_nxt = tcw_pkg::ST_READ;
          end
        end
      end
      tcw_pkg::ST_READ: begin
        state_nxt = tcw_pkg::ST_IDLE;
      end
      tcw_pkg::ST_FILL: begin
        if (fill_last) begin
          state_nxt = tcw_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tcw_pkg::ST_IDLE;
    endcase
  end

  // Cursor, rotation and fill sequencer updates
  always_comb begin
    row_nxt       = row_r;
    col_nxt       = col_r;
    top_nxt       = top_r;
    fill_addr_nxt = fill_addr_r;
    fill_cnt_nxt  = fill_cnt_r;
    fill_val_nxt  = fill_val_r;
    fill_rep_nxt  = fill_rep_r;
    scr_nxt       = scr_r;
    if (state_r == tcw_pkg::ST_FILL) begin
      fill_addr_nxt = fill_addr_r + AW'(1);
      fill_cnt_nxt  = fill_cnt_r - CW'(1);
    end else if (in_fire) begin
      if (is_clr) begin
        row_nxt       = '0;
        col_nxt       = '0;
        top_nxt       = '0;
        fill_addr_nxt = '0;
        fill_cnt_nxt  = CW'(CELLS);
        fill_val_nxt  = {color_r, tcw_pkg::BLANK_CODE};
        fill_rep_nxt  = 1'b1;
        scr_nxt       = 1'b0;
      end else if (adv_row) begin
        col_nxt = '0;
        if (last_row) begin
          // old top row becomes the new bottom row and is blanked
          top_nxt       = (top_r == AW'(CELLS - COLUMNS)) ? '0 : top_r + AW'(COLUMNS);
          fill_addr_nxt = top_r;
          fill_cnt_nxt  = CW'(COLUMNS);
          fill_val_nxt  = {color_r, tcw_pkg::BLANK_CODE};
          fill_rep_nxt  = 1'b1;
          scr_nxt       = 1'b1;
        end else begin
          row_nxt = row_r + RW'(1);
        end
      end else if (is_put) begin
        col_nxt = col_r + CLW'(1);
      end
    end
  end

  // Outputs: memory access and result
  assign row_x = RWX'(row_nxt);
  assign col_x = CLX'(col_nxt);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = phys_addr;
    mem_wdata = {color_r, in_char_code};
    mem_re    = 1'b0;
    mem_raddr = phys_addr;
    res_load  = 1'b0;
    res.cursor_row = row_x[tcw_pkg::ROW_W-1:0];
    res.cursor_col = col_x[tcw_pkg::COL_W-1:0];
    res.cell_data  = '0;
    res.scrolled   = 1'b0;
    unique case (state_r)
      tcw_pkg::ST_IDLE: begin
        if (in_fire) begin
          mem_we   = is_put && !is_nl;
          mem_re   = is_read && in_range;
          res_load = !(is_clr || do_scroll || (is_read && in_range));
        end
      end
      tcw_pkg::ST_READ: begin
        res_load      = 1'b1;
        res.cell_data = mem_rdata;
      end
      tcw_pkg::ST_FILL: begin
        mem_we       = 1'b1;
        mem_waddr    = fill_addr_r;
        mem_wdata    = fill_val_r;
        res_load     = fill_last && fill_rep_r;
        res.scrolled = scr_r;
      end
      default: ;
    endcase
  end

  // Control registers; reset starts the clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tcw_pkg::ST_FILL;
      row_r       <= '0;
      col_r       <= '0;
      top_r       <= '0;
      fill_addr_r <= '0;
      fill_cnt_r  <= CW'(CELLS);
      fill_val_r  <= {tcw_pkg::RESET_COLOR, tcw_pkg::BLANK_CODE};
      fill_rep_r  <= 1'b0;
      scr_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      top_r       <= top_nxt;
      fill_addr_r <= fill_addr_nxt;
      fill_cnt_r  <= fill_cnt_nxt;
      fill_val_r  <= fill_val_nxt;
      fill_rep_r  <= fill_rep_nxt;
      scr_r       <= scr_nxt;
    end
  end

  // Checks
  a_fill_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tcw_pkg::ST_FILL) |-> (fill_cnt_r != '0))
    else $error("fill sequencer running with zero count");

  a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re))
    else $error("memory write and read in the same cycle");

  a_scroll_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && do_scroll) |=> (state_r == tcw_pkg::ST_FILL) && (fill_cnt_r == CW'(COLUMNS)))
    else $error("scroll did not start a one-row fill");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    (row_r <= RW'(ROWS - 1)) && (col_r <= CLW'(COLUMNS - 1)) && (SW'(top_r) < SW'(CELLS)))
    else $error("cursor or row base out of range");

endmodule

`default_nettype wire
